>>> hdl/edwt_pkg.sv
// Shared constants and types for the debounced encoder window trigger.
package edwt_pkg;

  // Default build parameters.
  localparam int FILTER_TAPS_DEF = 5;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed widths of the register file and of the reported count.
  localparam int REG_W   = 16;
  localparam int PULSE_W = 16;
  localparam int IDX_W   = 2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [IDX_W-1:0] REG_PERIOD       = 2'd2;

  // Register reset values.
  localparam logic [REG_W-1:0] WINDOW_START_RST = 16'd50;
  localparam logic [REG_W-1:0] WINDOW_END_RST   = 16'd60;
  localparam logic [REG_W-1:0] PERIOD_RST       = 16'd100;

  typedef struct packed {
    logic [REG_W-1:0] window_start;
    logic [REG_W-1:0] window_end;
    logic [REG_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic               trigger;
    logic               filtered_level;
    logic               rising_edge;
    logic [PULSE_W-1:0] pulse_count;
  } res_t;

endpackage

>>> hdl/edwt_in_if.sv
// Request channel carrying one raw encoder pin sample.
interface edwt_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

>>> hdl/edwt_out_if.sv
// Result channel carrying the trigger, the debounced level and the pulse count.
interface edwt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         trigger;
  logic                         filtered_level;
  logic                         rising_edge;
  logic [edwt_pkg::PULSE_W-1:0] pulse_count;

  modport source (output valid, output trigger, output filtered_level,
                  output rising_edge, output pulse_count, input ready);
  modport sink (input valid, input trigger, input filtered_level,
                input rising_edge, input pulse_count, output ready);
endinterface

>>> hdl/encoder_debounce_window_trigger.sv
// Top level of the debounced encoder pulse counter with window trigger.
//
// One request carries one raw encoder pin sample and yields exactly one result:
// trigger level, debounced level, rising-edge flag and pulse count after that
// sample. The block sustains one request per clock while the result side is ready. A
// request is registered on entry, the debounce, count and window update runs once the
// output register is free, and the result lands in the output register, which drives
// out valid. The entry register and the output register each hold one item; while a
// result waits, at most one further request is taken. Registers window_start,
// window_end and period are to be written through the cfg port while no request is
// in flight; the block itself does not enforce this. Unknown indexes are ignored.
module encoder_debounce_window_trigger #(
  parameter int FILTER_TAPS = edwt_pkg::FILTER_TAPS_DEF,
  parameter int COUNT_WIDTH = edwt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  edwt_in_if.sink                      in_chan,
  edwt_out_if.source                   out_chan,
  input  logic                         cfg_we,
  input  logic [edwt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [edwt_pkg::REG_W-1:0]   cfg_wdata
);

  edwt_pkg::cfg_t cfg_r;

  logic           s1_valid_r;
  logic           s1_pin_r;
  logic           out_valid_r;
  edwt_pkg::res_t out_res_r;
  edwt_pkg::res_t step_res;
  logic           s2_adv;
  logic           in_take;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start <= edwt_pkg::WINDOW_START_RST;
      cfg_r.window_end   <= edwt_pkg::WINDOW_END_RST;
      cfg_r.period       <= edwt_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edwt_pkg::REG_WINDOW_START: cfg_r.window_start <= cfg_wdata;
        edwt_pkg::REG_WINDOW_END:   cfg_r.window_end   <= cfg_wdata;
        edwt_pkg::REG_PERIOD:       cfg_r.period       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Flow control: the output register frees when empty or taken this cycle.
  assign s2_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s2_adv;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Entry register for the pin sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin_r <= in_chan.pin_level;
    end
  end

  edwt_core #(
    .FILTER_TAPS (FILTER_TAPS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s2_adv),
    .pin_level (s1_pin_r),
    .cfg       (cfg_r),
    .res       (step_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.trigger        = out_res_r.trigger;
  assign out_chan.filtered_level = out_res_r.filtered_level;
  assign out_chan.rising_edge    = out_res_r.rising_edge;
  assign out_chan.pulse_count    = out_res_r.pulse_count;

  // Both item registers come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid_r && !s1_valid_r)
    else $error("item registers not empty after reset");

  // A stalled result is never overwritten by a new step.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !s2_adv)
    else $error("result overwritten while stalled");

  // A pending sample stays in the entry register until it steps the core.
  a_s1_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_adv |=> s1_valid_r && $stable(s1_pin_r))
    else $error("pending sample lost");

endmodule

>>> hdl/edwt_core.sv
// Debounce filter, pulse counter and window trigger state with its update logic.
module edwt_core #(
  parameter int FILTER_TAPS = edwt_pkg::FILTER_TAPS_DEF,
  parameter int COUNT_WIDTH = edwt_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic           pin_level,
  input  edwt_pkg::cfg_t cfg,
  output edwt_pkg::res_t res
);

  localparam int HIST_W = FILTER_TAPS - 1;
  localparam int CMP_W  = (COUNT_WIDTH > edwt_pkg::REG_W) ? COUNT_WIDTH : edwt_pkg::REG_W;

  logic [HIST_W-1:0]      hist_r, hist_nxt;
  logic                   deb_r, deb_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   trig_r, trig_nxt;

  logic [FILTER_TAPS-1:0] window;
  logic                   rise;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_inc_x, cnt_nxt_x;
  logic                   in_window;
  logic                   trig_edge;
  logic                   period_hit;

  // Newest sample joins the history; hysteresis needs all taps equal to switch.
  always_comb begin
    window   = {hist_r, pin_level};
    hist_nxt = window[HIST_W-1:0];
    deb_nxt  = deb_r ? (|window) : (&window);
    rise     = !deb_r && deb_nxt;
  end

  // Count the edge, evaluate the window, then apply the period restart.
  always_comb begin
    cnt_inc    = rise ? (cnt_r + 1'b1) : cnt_r;
    cnt_inc_x  = CMP_W'(cnt_inc);
    in_window  = (cnt_inc_x >= CMP_W'(cfg.window_start)) &&
                 (cnt_inc_x <  CMP_W'(cfg.window_end));
    trig_edge  = rise ? in_window : trig_r;
    period_hit = (cnt_inc_x == CMP_W'(cfg.period));
    cnt_nxt    = period_hit ? '0 : cnt_inc;
    trig_nxt   = period_hit ? 1'b0 : trig_edge;
    cnt_nxt_x  = CMP_W'(cnt_nxt);
  end

  // Result of this step, with the count reported on the fixed field width.
  always_comb begin
    res.trigger        = trig_nxt;
    res.filtered_level = deb_nxt;
    res.rising_edge    = rise;
    res.pulse_count    = cnt_nxt_x[edwt_pkg::PULSE_W-1:0];
  end

  // State registers advance once per accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      deb_r  <= 1'b0;
      cnt_r  <= '0;
      trig_r <= 1'b0;
    end else if (step_en) begin
      hist_r <= hist_nxt;
      deb_r  <= deb_nxt;
      cnt_r  <= cnt_nxt;
      trig_r <= trig_nxt;
    end
  end

  // A reported rising edge always leaves the filtered level high.
  a_rise_level: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.rising_edge |-> res.filtered_level)
    else $error("rising edge reported with low filtered level");

  // The trigger can only turn on through a counted edge.
  a_trig_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.trigger && !trig_r |-> res.rising_edge)
    else $error("trigger turned on without a rising edge");

  // Without a sample the state must not move.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(cnt_r) && $stable(deb_r) && $stable(trig_r) && $stable(hist_r))
    else $error("state changed without an accepted sample");

endmodule
